// File: sv/pdwc_pkg.sv
// shared types and constants for the pump duty window controller
package pdwc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned SpanWidth = 17;
   localparam int unsigned HourWidth = 5;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth = SpanWidth;

   typedef enum logic [1:0] {
      MODE_OFF      = 2'd0,
      MODE_PUMPING  = 2'd1,
      MODE_RESTING  = 2'd2,
      MODE_OVERRIDE = 2'd3
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ENABLED    = 3'd0,
      CSR_UP_TIME    = 3'd1,
      CSR_REST_TIME  = 3'd2,
      CSR_START_HOUR = 3'd3,
      CSR_END_HOUR   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                 enabled;
      logic [SpanWidth-1:0] up_time;
      logic [SpanWidth-1:0] rest_time;
      logic [HourWidth-1:0] start_hour;
      logic [HourWidth-1:0] end_hour;
   } cfg_type;

   typedef struct packed {
      mode_type             mode;
      logic [TimeWidth-1:0] pump_started_at;
      logic [TimeWidth-1:0] rest_started_at;
      logic                 previous_level;
      logic                 drive_latch;
   } state_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_seconds;
      logic [HourWidth-1:0] hour_of_day;
      logic                 time_valid;
      logic                 level_raw;
   } tick_type;

   typedef struct packed {
      logic     drive_high;
      mode_type pump_state;
      logic     level_active;
      logic     level_changed;
   } result_type;

endpackage

// File: sv/pdwc_step.sv
// next-state and result logic for one tick word
module pdwc_step (
   input  pdwc_pkg::cfg_type    cfg,
   input  pdwc_pkg::state_type  state,
   input  pdwc_pkg::tick_type   tick,
   output pdwc_pkg::state_type  state_next,
   output pdwc_pkg::result_type result
);

   logic                           active;
   logic                           level;
   logic                           in_window;
   logic                           pump_expired;
   logic                           rest_expired;
   logic [pdwc_pkg::TimeWidth-1:0] pump_deadline;
   logic [pdwc_pkg::TimeWidth-1:0] rest_deadline;
   pdwc_pkg::state_type            base;

   assign active    = cfg.enabled & tick.time_valid;
   assign level     = ~tick.level_raw;
   assign in_window = (cfg.start_hour <= tick.hour_of_day) &&
                      (tick.hour_of_day < cfg.end_hour);

   // window check forces override and clears timestamps before the mode step
   always_comb begin
      base                = state;
      base.previous_level = level;
      if (!in_window) begin
         base.mode            = pdwc_pkg::MODE_OVERRIDE;
         base.pump_started_at = '0;
         base.rest_started_at = '0;
      end
   end

   assign pump_deadline = base.pump_started_at +
                          {{(pdwc_pkg::TimeWidth-pdwc_pkg::SpanWidth){1'b0}}, cfg.up_time};
   assign rest_deadline = base.rest_started_at +
                          {{(pdwc_pkg::TimeWidth-pdwc_pkg::SpanWidth){1'b0}}, cfg.rest_time};
   assign pump_expired  = pump_deadline < tick.now_seconds;
   assign rest_expired  = rest_deadline < tick.now_seconds;

   always_comb begin
      state_next = state;
      if (active) begin
         state_next = base;
         unique case (base.mode)
            pdwc_pkg::MODE_OFF: begin
               if (level) begin
                  state_next.mode            = pdwc_pkg::MODE_PUMPING;
                  state_next.pump_started_at = tick.now_seconds;
               end
            end
            pdwc_pkg::MODE_PUMPING: begin
               state_next.drive_latch = 1'b0;
               if (pump_expired) begin
                  state_next.mode            = pdwc_pkg::MODE_RESTING;
                  state_next.rest_started_at = tick.now_seconds;
               end
               if (!level) begin
                  state_next.mode = pdwc_pkg::MODE_OFF;
               end
            end
            pdwc_pkg::MODE_RESTING: begin
               state_next.drive_latch = 1'b1;
               if (rest_expired) begin
                  state_next.mode            = pdwc_pkg::MODE_PUMPING;
                  state_next.pump_started_at = tick.now_seconds;
               end
            end
            default: begin
               state_next.drive_latch = ~in_window;
               if (in_window) begin
                  state_next.mode = pdwc_pkg::MODE_OFF;
               end
            end
         endcase
      end
   end

   always_comb begin
      result.drive_high    = state_next.drive_latch;
      result.pump_state    = state_next.mode;
      result.level_active  = active & level;
      result.level_changed = active & (level ^ state.previous_level);
   end

endmodule

// File: sv/pump_duty_window_controller.sv
// pump duty window controller top level: input register, state update, result register
// a tick word is held in the input register until the result register is free; the state
// update then writes its result word into the result register
// throughput: one word per cycle unless rsp_stall holds the output; the state update is a
// single pass of compares and one 32-bit add per timer between the input and result registers
// reset: synchronous active high; clears config, mode, timestamps and both pipeline valids
module pump_duty_window_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pdwc_pkg::TimeWidth-1:0]      req_now_seconds,
   input  logic [pdwc_pkg::HourWidth-1:0]      req_hour_of_day,
   input  logic                                req_time_valid,
   input  logic                                req_level_raw,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drive_high,
   output logic [1:0]                          rsp_pump_state,
   output logic                                rsp_level_active,
   output logic                                rsp_level_changed,
   input  logic                                csr_write,
   input  logic [pdwc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pdwc_pkg::CsrDataWidth-1:0]   csr_wdata
);

   pdwc_pkg::cfg_type    cfg_ff;
   pdwc_pkg::cfg_type    cfg_in;
   pdwc_pkg::state_type  state_ff;
   pdwc_pkg::state_type  state_in;
   pdwc_pkg::state_type  state_next;
   pdwc_pkg::tick_type   tick_ff;
   pdwc_pkg::tick_type   tick_in;
   pdwc_pkg::result_type result_ff;
   pdwc_pkg::result_type result_in;
   pdwc_pkg::result_type step_result;
   logic                 tick_valid_ff;
   logic                 tick_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (pdwc_pkg::csr_index_type'(csr_index))
            pdwc_pkg::CSR_ENABLED:    cfg_in.enabled    = csr_wdata[0];
            pdwc_pkg::CSR_UP_TIME:    cfg_in.up_time    = csr_wdata;
            pdwc_pkg::CSR_REST_TIME:  cfg_in.rest_time  = csr_wdata;
            pdwc_pkg::CSR_START_HOUR: cfg_in.start_hour = csr_wdata[pdwc_pkg::HourWidth-1:0];
            pdwc_pkg::CSR_END_HOUR:   cfg_in.end_hour   = csr_wdata[pdwc_pkg::HourWidth-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = tick_valid_ff & out_free;
   assign req_stall = tick_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign tick_in.now_seconds = req_now_seconds;
   assign tick_in.hour_of_day = req_hour_of_day;
   assign tick_in.time_valid  = req_time_valid;
   assign tick_in.level_raw   = req_level_raw;

   assign tick_valid_in = req_take | (tick_valid_ff & ~advance);
   assign rsp_valid_in  = advance | (rsp_valid_ff & rsp_stall);

   pdwc_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .tick       (tick_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   assign state_in  = advance ? state_next : state_ff;
   assign result_in = advance ? step_result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         state_ff      <= '0;
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= tick_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_high    = result_ff.drive_high;
   assign rsp_pump_state    = result_ff.pump_state;
   assign rsp_level_active  = result_ff.level_active;
   assign rsp_level_changed = result_ff.level_changed;

   assert property (@(posedge clock) reset |=> (!rsp_valid_ff && !tick_valid_ff))
      else $error("pipeline valid set right after reset");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (result_ff.pump_state == pdwc_pkg::MODE_OVERRIDE)) |-> rsp_drive_high)
      else $error("override result without the pin driven high");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_level_changed && rsp_valid_ff) |-> cfg_ff.enabled)
      else $error("level change flagged while disabled");

endmodule

// File: verif/pump_duty_window_controller_tb.sv
// self-checking testbench for the pump duty window controller
`timescale 1ns / 1ps

module pump_duty_window_controller_tb;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainGuard = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [pdwc_pkg::TimeWidth-1:0]     req_now_seconds = '0;
   logic [pdwc_pkg::HourWidth-1:0]     req_hour_of_day = '0;
   logic                               req_time_valid = 1'b0;
   logic                               req_level_raw = 1'b1;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_drive_high;
   logic [1:0]                         rsp_pump_state;
   logic                               rsp_level_active;
   logic                               rsp_level_changed;
   logic                               csr_write = 1'b0;
   logic [pdwc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [pdwc_pkg::CsrDataWidth-1:0]  csr_wdata = '0;

   pdwc_pkg::cfg_type     cfg_now;
   pdwc_pkg::state_type   pump_model;
   pdwc_pkg::result_type  expected_q[$];

   int unsigned fail_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;

   int unsigned stall_mode = 0;
   int unsigned stall_phase_left = 0;

   pump_duty_window_controller u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_seconds   (req_now_seconds),
      .req_hour_of_day   (req_hour_of_day),
      .req_time_valid    (req_time_valid),
      .req_level_raw     (req_level_raw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_high    (rsp_drive_high),
      .rsp_pump_state    (rsp_pump_state),
      .rsp_level_active  (rsp_level_active),
      .rsp_level_changed (rsp_level_changed),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            stall_phase_left = $urandom_range(300, 20);
         end else begin
            stall_phase_left = stall_phase_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(3, 0) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(9, 0) < 6);
            end
            default: begin
               rsp_stall <= ((cycle_count % 5) < 2);
            end
         endcase
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d (result %0d, cycle %0d)",
               what, got, want, results_checked, cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin : check_results
      pdwc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result word", 0, 0);
         end else begin
            want = expected_q.pop_front();
            results_checked++;
            if (rsp_drive_high !== want.drive_high)
               report_mismatch("drive_high", 32'(rsp_drive_high), 32'(want.drive_high));
            if (rsp_pump_state !== want.pump_state)
               report_mismatch("pump_state", 32'(rsp_pump_state), 32'(want.pump_state));
            if (rsp_level_active !== want.level_active)
               report_mismatch("level_active", 32'(rsp_level_active),
                               32'(want.level_active));
            if (rsp_level_changed !== want.level_changed)
               report_mismatch("level_changed", 32'(rsp_level_changed),
                               32'(want.level_changed));
         end
      end
   end

   function automatic bit hour_in_window(input logic [pdwc_pkg::HourWidth-1:0] hour);
      return (cfg_now.start_hour <= hour) && (hour < cfg_now.end_hour);
   endfunction

   function automatic bit timer_expired(input logic [pdwc_pkg::TimeWidth-1:0] since,
                                        input logic [pdwc_pkg::SpanWidth-1:0] span,
                                        input logic [pdwc_pkg::TimeWidth-1:0] now);
      logic [pdwc_pkg::TimeWidth-1:0] deadline;
      deadline = since + {{(pdwc_pkg::TimeWidth-pdwc_pkg::SpanWidth){1'b0}}, span};
      return deadline < now;
   endfunction

   task automatic predict_tick(input pdwc_pkg::tick_type t, output pdwc_pkg::result_type r);
      logic level;
      logic changed;
      level = 1'b0;
      changed = 1'b0;
      if (cfg_now.enabled && t.time_valid) begin
         level = ~t.level_raw;
         changed = (level != pump_model.previous_level);
         pump_model.previous_level = level;
         if (!hour_in_window(t.hour_of_day)) begin
            pump_model.mode = pdwc_pkg::MODE_OVERRIDE;
            pump_model.pump_started_at = '0;
            pump_model.rest_started_at = '0;
         end
         case (pump_model.mode)
            pdwc_pkg::MODE_OFF: begin
               if (level) begin
                  pump_model.mode = pdwc_pkg::MODE_PUMPING;
                  pump_model.pump_started_at = t.now_seconds;
               end
            end
            pdwc_pkg::MODE_PUMPING: begin
               pump_model.drive_latch = 1'b0;
               if (timer_expired(pump_model.pump_started_at, cfg_now.up_time,
                                 t.now_seconds)) begin
                  pump_model.mode = pdwc_pkg::MODE_RESTING;
                  pump_model.rest_started_at = t.now_seconds;
               end
               if (!level)
                  pump_model.mode = pdwc_pkg::MODE_OFF;
            end
            pdwc_pkg::MODE_RESTING: begin
               pump_model.drive_latch = 1'b1;
               if (timer_expired(pump_model.rest_started_at, cfg_now.rest_time,
                                 t.now_seconds)) begin
                  pump_model.mode = pdwc_pkg::MODE_PUMPING;
                  pump_model.pump_started_at = t.now_seconds;
               end
            end
            default: begin
               pump_model.drive_latch = 1'b1;
               if (hour_in_window(t.hour_of_day)) begin
                  pump_model.drive_latch = 1'b0;
                  pump_model.mode = pdwc_pkg::MODE_OFF;
               end
            end
         endcase
      end
      r.drive_high = pump_model.drive_latch;
      r.pump_state = pump_model.mode;
      r.level_active = level;
      r.level_changed = changed;
   endtask

   task automatic send_tick(input pdwc_pkg::tick_type t);
      int unsigned gap;
      pdwc_pkg::result_type r;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(40, 1);
      end
      req_valid <= 1'b1;
      req_now_seconds <= t.now_seconds;
      req_hour_of_day <= t.hour_of_day;
      req_time_valid <= t.time_valid;
      req_level_raw <= t.level_raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tick(t, r);
      expected_q.push_back(r);
      ticks_sent++;
      burst_left--;
   endtask

   task automatic drain_results();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0 && guard < DrainGuard) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input pdwc_pkg::csr_index_type idx,
                            input logic [pdwc_pkg::CsrDataWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input pdwc_pkg::cfg_type c);
      write_csr(pdwc_pkg::CSR_ENABLED, pdwc_pkg::CsrDataWidth'(c.enabled));
      write_csr(pdwc_pkg::CSR_UP_TIME, c.up_time);
      write_csr(pdwc_pkg::CSR_REST_TIME, c.rest_time);
      write_csr(pdwc_pkg::CSR_START_HOUR, pdwc_pkg::CsrDataWidth'(c.start_hour));
      write_csr(pdwc_pkg::CSR_END_HOUR, pdwc_pkg::CsrDataWidth'(c.end_hour));
      csr_write <= 1'b0;
      cfg_now = c;
      settings_applied++;
   endtask

   function automatic pdwc_pkg::cfg_type make_cfg(input logic en,
                                        input logic [pdwc_pkg::SpanWidth-1:0] up,
                                        input logic [pdwc_pkg::SpanWidth-1:0] rest,
                                        input logic [pdwc_pkg::HourWidth-1:0] first,
                                        input logic [pdwc_pkg::HourWidth-1:0] last);
      pdwc_pkg::cfg_type c;
      c.enabled = en;
      c.up_time = up;
      c.rest_time = rest;
      c.start_hour = first;
      c.end_hour = last;
      return c;
   endfunction

   function automatic pdwc_pkg::tick_type tick_of(input logic [pdwc_pkg::TimeWidth-1:0] now,
                                        input logic [pdwc_pkg::HourWidth-1:0] hour,
                                        input logic valid, input logic raw);
      pdwc_pkg::tick_type t;
      t.now_seconds = now;
      t.hour_of_day = hour;
      t.time_valid = valid;
      t.level_raw = raw;
      return t;
   endfunction

   task automatic test_reset_idle();
      send_tick(tick_of(32'hFFFF_FFFF, 5'd23, 1'b1, 1'b0));
      send_tick(tick_of(32'h0000_0000, 5'd0, 1'b0, 1'b1));
      drain_results();
   endtask

   task automatic test_pump_cycle();
      configure(make_cfg(1'b1, 17'd10, 17'd5, 5'd0, 5'd24));
      send_tick(tick_of(32'd50, 5'd8, 1'b0, 1'b0));
      send_tick(tick_of(32'd100, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'd110, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'd111, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'd116, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'd117, 5'd8, 1'b1, 1'b1));
      send_tick(tick_of(32'd118, 5'd8, 1'b1, 1'b0));
      // up time runs out on the same tick that the level goes away
      send_tick(tick_of(32'd128, 5'd8, 1'b1, 1'b1));
      send_tick(tick_of(32'd129, 5'd8, 1'b1, 1'b1));
      // deadline wraps past the top of the 32-bit range
      send_tick(tick_of(32'hFFFF_FFF8, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'hFFFF_FFFF, 5'd8, 1'b1, 1'b0));
      send_tick(tick_of(32'h0000_0000, 5'd8, 1'b1, 1'b0));
      drain_results();
   endtask

   task automatic test_window_override();
      configure(make_cfg(1'b1, 17'd3, 17'd3, 5'd6, 5'd18));
      send_tick(tick_of(32'd1000, 5'd7, 1'b1, 1'b0));
      send_tick(tick_of(32'd1001, 5'd18, 1'b1, 1'b0));
      send_tick(tick_of(32'd1002, 5'd5, 1'b1, 1'b0));
      send_tick(tick_of(32'd1003, 5'd6, 1'b1, 1'b0));
      send_tick(tick_of(32'd1004, 5'd17, 1'b1, 1'b0));
      send_tick(tick_of(32'd1005, 5'd31, 1'b1, 1'b1));
      drain_results();
      configure(make_cfg(1'b1, 17'd0, 17'd86400, 5'd24, 5'd24));
      send_tick(tick_of(32'd2000, 5'd0, 1'b1, 1'b0));
      send_tick(tick_of(32'd2001, 5'd23, 1'b1, 1'b0));
      drain_results();
      configure(make_cfg(1'b1, 17'd86400, 17'd0, 5'd20, 5'd4));
      send_tick(tick_of(32'd2002, 5'd2, 1'b1, 1'b0));
      drain_results();
      configure(make_cfg(1'b0, 17'd86400, 17'd0, 5'd20, 5'd4));
      send_tick(tick_of(32'd2003, 5'd10, 1'b1, 1'b1));
      drain_results();
   endtask

   task automatic run_phase(input pdwc_pkg::cfg_type c, input int unsigned count,
                            input bit pause_mid);
      pdwc_pkg::tick_type t;
      logic [pdwc_pkg::TimeWidth-1:0] now_cur;
      logic level_cur;
      int unsigned hint;
      int unsigned hi;
      configure(c);
      now_cur = ($urandom_range(1, 0) == 0) ? $urandom : 32'hFFFF_FF00;
      level_cur = 1'($urandom_range(1, 0));
      hint = ((c.up_time > c.rest_time) ? c.up_time : c.rest_time) / 4 + 3;
      for (int unsigned i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2)
            drain_results();
         if ($urandom_range(9, 0) == 0) begin
            t = tick_of($urandom, pdwc_pkg::HourWidth'($urandom_range(31, 0)),
                        1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
         end else begin
            if ($urandom_range(39, 0) == 0)
               now_cur = now_cur + $urandom;
            else
               now_cur = now_cur + $urandom_range(hint, 0);
            if ($urandom_range(5, 0) == 0)
               level_cur = ~level_cur;
            t.now_seconds = now_cur;
            if (c.start_hour < c.end_hour && $urandom_range(15, 0) != 0) begin
               hi = c.end_hour - 1;
               t.hour_of_day = pdwc_pkg::HourWidth'($urandom_range(hi, c.start_hour));
            end else begin
               t.hour_of_day = pdwc_pkg::HourWidth'($urandom_range(31, 0));
            end
            t.time_valid = ($urandom_range(15, 0) != 0);
            t.level_raw = ~level_cur;
         end
         send_tick(t);
      end
      drain_results();
   endtask

   task automatic test_random_phases();
      pdwc_pkg::cfg_type c;
      int unsigned count;
      for (int unsigned p = 0; p < 12; p++) begin
         count = 150;
         case (p)
            0: c = make_cfg(1'b1, 17'd0, 17'd0, 5'd0, 5'd24);
            1: c = make_cfg(1'b1, 17'd86400, 17'd86400, 5'd0, 5'd24);
            2: c = make_cfg(1'b1, 17'h1FFFF, 17'h1FFFF, 5'd0, 5'd31);
            3: c = make_cfg(1'b1, 17'd4, 17'd4, 5'd12, 5'd12);
            4: c = make_cfg(1'b1, 17'd6, 17'd2, 5'd18, 5'd6);
            5: begin
               c = make_cfg(1'b0, 17'd5, 17'd5, 5'd0, 5'd24);
               count = 30;
            end
            default: begin
               c = make_cfg(1'b1, pdwc_pkg::SpanWidth'($urandom_range(20, 0)),
                            pdwc_pkg::SpanWidth'($urandom_range(20, 0)),
                            pdwc_pkg::HourWidth'($urandom_range(12, 0)),
                            pdwc_pkg::HourWidth'($urandom_range(24, 10)));
            end
         endcase
         run_phase(c, count, (p == 7));
      end
   endtask

   initial begin
      cfg_now = make_cfg(1'b0, '0, '0, '0, '0);
      pump_model.mode = pdwc_pkg::MODE_OFF;
      pump_model.pump_started_at = '0;
      pump_model.rest_started_at = '0;
      pump_model.previous_level = 1'b0;
      pump_model.drive_latch = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_idle();
      test_pump_cycle();
      test_window_override();
      test_random_phases();

      drain_results();
      if (expected_q.size() != 0)
         report_mismatch("results never arrived", 0, expected_q.size());
      $display("ran %0d tick words through %0d register settings, %0d results checked",
               ticks_sent, settings_applied, results_checked);
      $display("covered pump cycling, timer wrap, window override and idle ticks");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
